// ===== sv/tmw_pkg.sv =====
`timescale 1ns / 1ps

package tmw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int LAST_ROW_BASE  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int CELL_W = 16;

    // Fixed field widths on the ports
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CADDR_W  = 11;
    localparam int CPOS_W   = 11;

    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'd10;
    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'd8;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR   = 8'd7;
    localparam logic [CELL_W-1:0] BLANK_DEFAULT  = {DEFAULT_ATTR, BLANK_CHAR};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_wr_req;

endpackage

// ===== sv/tmw_ram.sv =====
`timescale 1ns / 1ps

module tmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tmw_seq.sv =====
`timescale 1ns / 1ps

module tmw_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tmw_pkg::ACTION_W-1:0]  i_action,
    input  logic [tmw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tmw_pkg::CADDR_W-1:0]   i_cell_address,
    input  logic                          i_cfg_we,
    input  logic [tmw_pkg::ATTR_W-1:0]    i_cfg_wdata,
    output logic [tmw_pkg::ADDR_W-1:0]    o_rd_addr,
    input  logic [tmw_pkg::CELL_W-1:0]    i_rd_data,
    output tmw_pkg::t_wr_req              o_wr,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic [tmw_pkg::ADDR_W-1:0]    o_res_pos,
    output logic [tmw_pkg::CELL_W-1:0]    o_res_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_FILL   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [tmw_pkg::ROW_W-1:0]      r_row, n_row;
    logic [tmw_pkg::COL_W-1:0]      r_col, n_col;
    logic [tmw_pkg::ADDR_W-1:0]     r_pos, n_pos;
    logic [tmw_pkg::ATTR_W-1:0]     r_attr, n_attr;
    logic [tmw_pkg::ADDR_W-1:0]     r_ptr, n_ptr;
    logic [tmw_pkg::CELL_W-1:0]     r_fill_data, n_fill_data;
    logic                           r_emit, n_emit;
    logic                           r_cp_vld, n_cp_vld;
    logic [tmw_pkg::ADDR_W-1:0]     r_cp_addr, n_cp_addr;
    logic                           r_rd_ok, n_rd_ok;
    logic [tmw_pkg::CELL_W-1:0]     r_res_data, n_res_data;

    logic                           accept;
    logic                           at_last_row;
    logic                           at_last_col;
    logic                           go_next_row;
    logic [tmw_pkg::ADDR_W-1:0]     pos_next_row;
    logic [tmw_pkg::ADDR_W-1:0]     fill_end;

    assign o_in_stall   = (r_state != S_IDLE);
    assign accept       = i_in_valid && (r_state == S_IDLE);
    assign at_last_row  = (r_row == tmw_pkg::ROW_W'(tmw_pkg::SCREEN_ROWS - 1));
    assign at_last_col  = (r_col == tmw_pkg::COL_W'(tmw_pkg::SCREEN_COLUMNS - 1));
    assign pos_next_row = r_pos - tmw_pkg::ADDR_W'(r_col)
                        + tmw_pkg::ADDR_W'(tmw_pkg::SCREEN_COLUMNS);
    assign fill_end     = tmw_pkg::ADDR_W'(tmw_pkg::CELL_COUNT - 1);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_attr      = r_attr;
        n_ptr       = r_ptr;
        n_fill_data = r_fill_data;
        n_emit      = r_emit;
        n_cp_vld    = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_rd_ok     = r_rd_ok;
        n_res_data  = r_res_data;
        go_next_row = 1'b0;
        o_rd_addr   = r_ptr;
        o_wr        = '0;

        if (i_cfg_we) begin
            n_attr = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = tmw_pkg::ADDR_W'(i_cell_address);
                if (accept) begin
                    n_res_data = '0;
                    n_state    = S_RESULT;
                    unique case (i_action)
                        tmw_pkg::ACT_PUT: begin
                            if (i_char_code == tmw_pkg::NEWLINE_CHAR) begin
                                go_next_row = 1'b1;
                            end else if (i_char_code == tmw_pkg::BACKSPACE_CHAR) begin
                                if (r_col != '0) begin
                                    n_col      = r_col - 1'b1;
                                    n_pos      = r_pos - 1'b1;
                                    o_wr.en    = 1'b1;
                                    o_wr.addr  = r_pos - 1'b1;
                                    o_wr.data  = {r_attr, tmw_pkg::BLANK_CHAR};
                                end
                            end else begin
                                o_wr.en   = 1'b1;
                                o_wr.addr = r_pos;
                                o_wr.data = {r_attr, i_char_code};
                                if (at_last_col) begin
                                    go_next_row = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        end
                        tmw_pkg::ACT_READ: begin
                            n_rd_ok = (32'(i_cell_address) < tmw_pkg::CELL_COUNT);
                            n_state = S_READ;
                        end
                        tmw_pkg::ACT_CLEAR: begin
                            n_attr      = tmw_pkg::DEFAULT_ATTR;
                            n_row       = '0;
                            n_col       = '0;
                            n_pos       = '0;
                            n_ptr       = '0;
                            n_fill_data = tmw_pkg::BLANK_DEFAULT;
                            n_emit      = 1'b1;
                            n_state     = S_FILL;
                        end
                        default: begin
                        end
                    endcase

                    if (go_next_row) begin
                        n_col = '0;
                        if (at_last_row) begin
                            // stay on the bottom row and shift the screen up
                            n_pos   = tmw_pkg::ADDR_W'(tmw_pkg::LAST_ROW_BASE);
                            n_ptr   = tmw_pkg::ADDR_W'(tmw_pkg::SCREEN_COLUMNS);
                            n_state = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                            n_pos = pos_next_row;
                        end
                    end
                end
            end
            S_READ: begin
                n_res_data = r_rd_ok ? i_rd_data : '0;
                n_state    = S_RESULT;
            end
            S_SCROLL: begin
                // read one row down, write back in the next cycle
                o_rd_addr = r_ptr;
                n_cp_vld  = 1'b1;
                n_cp_addr = r_ptr - tmw_pkg::ADDR_W'(tmw_pkg::SCREEN_COLUMNS);
                if (r_ptr == fill_end) begin
                    n_ptr       = tmw_pkg::ADDR_W'(tmw_pkg::LAST_ROW_BASE);
                    n_fill_data = {r_attr, tmw_pkg::BLANK_CHAR};
                    n_emit      = 1'b1;
                    n_state     = S_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FILL: begin
                // hold the sweep while the last scroll copy drains
                if (!r_cp_vld) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_ptr;
                    o_wr.data = r_fill_data;
                    if (r_ptr == fill_end) begin
                        n_state = r_emit ? S_RESULT : S_IDLE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_RESULT: begin
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_cp_vld) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_cp_addr;
            o_wr.data = i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_row       <= '0;
            r_col       <= '0;
            r_pos       <= '0;
            r_attr      <= tmw_pkg::DEFAULT_ATTR;
            r_ptr       <= '0;
            r_fill_data <= tmw_pkg::BLANK_DEFAULT;
            r_emit      <= 1'b0;
            r_cp_vld    <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pos       <= n_pos;
            r_attr      <= n_attr;
            r_ptr       <= n_ptr;
            r_fill_data <= n_fill_data;
            r_emit      <= n_emit;
            r_cp_vld    <= n_cp_vld;
            r_rd_ok     <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr  <= n_cp_addr;
        r_res_data <= n_res_data;
    end

    assign o_res_valid = (r_state == S_RESULT);
    assign o_res_pos   = r_pos;
    assign o_res_data  = r_res_data;

endmodule

// ===== sv/text_mode_terminal_writer_top.sv =====
`timescale 1ns / 1ps
// A put, or action 3, goes from idle straight to the result state; a read passes through a
// read state first. The sequencer holds one item at a time and passes through its result
// state before taking the next beat. A put that scrolls first copies every row up by one
// and blanks the bottom row, and a clear blanks every cell with the default attribute.
// Reset: synchronous, active low; afterwards a fill pass writes a blank to every cell
// while o_in_stall stays high. Config writes are taken during it.
module text_mode_terminal_writer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tmw_pkg::ACTION_W-1:0]  i_action,
    input  logic [tmw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tmw_pkg::CADDR_W-1:0]   i_cell_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tmw_pkg::CPOS_W-1:0]    o_cursor_position,
    output logic [tmw_pkg::CELL_W-1:0]    o_cell_data,
    input  logic                          i_cfg_we,
    input  logic [tmw_pkg::ATTR_W-1:0]    i_cfg_wdata
);

    logic [tmw_pkg::ADDR_W-1:0] rd_addr;
    logic [tmw_pkg::CELL_W-1:0] rd_data;
    tmw_pkg::t_wr_req           wr;
    logic                       res_valid;
    logic                       res_stall;
    logic [tmw_pkg::ADDR_W-1:0] res_pos;
    logic [tmw_pkg::CELL_W-1:0] res_data;

    logic                       r_out_valid;
    logic [tmw_pkg::CPOS_W-1:0] r_out_pos;
    logic [tmw_pkg::CELL_W-1:0] r_out_data;

    tmw_ram #(
        .WIDTH (tmw_pkg::CELL_W),
        .DEPTH (tmw_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    tmw_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_cell_address (i_cell_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr           (wr),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_res_pos      (res_pos),
        .o_res_data     (res_data)
    );

    // output register frees the sequencer while a result waits
    assign res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && !res_stall) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && !res_stall) begin
            r_out_pos  <= tmw_pkg::CPOS_W'(res_pos);
            r_out_data <= res_data;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_data;

endmodule

// ===== sv/tmw_checker.sv =====
`timescale 1ns / 1ps

module tmw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tmw_pkg::CPOS_W-1:0]    o_cursor_position,
    input logic [tmw_pkg::CELL_W-1:0]    o_cell_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_cursor_position) && $stable(o_cell_data))
        else $error("result beat changed under stall");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cursor_position) < tmw_pkg::CELL_COUNT)
        else $error("cursor position off screen");

    // the blank fill pass blocks input right after reset
    a_init_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input taken during reset fill");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind text_mode_terminal_writer_top tmw_checker u_tmw_checker (.*);
